// ===== design/rvs_pkg.sv =====
// Shared types, opcodes and helper functions for the RV32I step block.
package rvs_pkg;

  localparam int MEM_BYTES_DEF = 4096;
  localparam int STACK_GAP     = 12;
  localparam logic [31:0] HALT_WORD = 32'hffff_ffff;

  localparam logic [6:0] OP_R      = 7'h33;
  localparam logic [6:0] OP_I      = 7'h13;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [2:0] F3_ADD = 3'd0;
  localparam logic [2:0] F3_SLL = 3'd1;
  localparam logic [2:0] F3_SLT = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR = 3'd4;
  localparam logic [2:0] F3_SR  = 3'd5;
  localparam logic [2:0] F3_OR  = 3'd6;
  localparam logic [2:0] F3_AND = 3'd7;

  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;

  localparam logic [2:0] F3_BEQ = 3'd0;
  localparam logic [2:0] F3_BNE = 3'd1;
  localparam logic [2:0] F3_BLT = 3'd4;
  localparam logic [2:0] F3_BGE = 3'd5;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0] instr_address;
    logic [31:0] next_address;
    logic        reg_write;
    logic [4:0]  dest_reg;
    logic [31:0] write_value;
    logic        branch_taken;
    logic        mem_write;
    logic        halted;
    status_t     status;
  } res_t;

  typedef struct packed {
    logic        ld;
    logic        st;
    logic [31:0] addr;
    logic [2:0]  f3;
    logic [2:0]  size;
    logic [31:0] sdata;
  } mem_req_t;

  function automatic logic [31:0] alu_op(input logic [2:0] f3, input logic alt,
                                         input logic [31:0] a, input logic [31:0] b);
    logic [31:0] r;
    unique case (f3)
      F3_ADD:  r = alt ? a - b : a + b;
      F3_SLL:  r = a << b[4:0];
      F3_SLT:  r = {31'd0, $signed(a) < $signed(b)};
      F3_XOR:  r = a ^ b;
      F3_SR:   r = alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      F3_OR:   r = a | b;
      F3_AND:  r = a & b;
      default: r = '0;
    endcase
    return r;
  endfunction

  // bytes come from four banks; byte k of the access sits in bank lo+k
  function automatic logic [31:0] load_value(input logic [3:0][7:0] q, input logic [1:0] lo,
                                             input logic [2:0] f3);
    logic [31:0] w;
    logic [31:0] r;
    w = {q[2'(lo + 2'd3)], q[2'(lo + 2'd2)], q[2'(lo + 2'd1)], q[lo]};
    unique case (f3)
      F3_LB:   r = {{24{w[7]}}, w[7:0]};
      F3_LH:   r = {{16{w[15]}}, w[15:0]};
      F3_LBU:  r = {24'd0, w[7:0]};
      F3_LHU:  r = {16'd0, w[15:0]};
      default: r = w;
    endcase
    return r;
  endfunction

endpackage

// ===== design/rvs_in_if.sv =====
// Instruction channel: valid/ready with one instruction word.
interface rvs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;

  modport source (output valid, output instruction, input ready);
  modport sink (input valid, input instruction, output ready);
endinterface

// ===== design/rvs_out_if.sv =====
// Result channel: valid/ready with the retired instruction's effects.
interface rvs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_address;
  logic [31:0] next_address;
  logic        reg_write;
  logic [4:0]  dest_reg;
  logic signed [31:0] write_value;
  logic        branch_taken;
  logic        mem_write;
  logic        halted;
  logic [1:0]  status;

  modport source (output valid, output instr_address, output next_address,
                  output reg_write, output dest_reg, output write_value,
                  output branch_taken, output mem_write, output halted,
                  output status, input ready);
  modport sink (input valid, input instr_address, input next_address,
                input reg_write, input dest_reg, input write_value,
                input branch_taken, input mem_write, input halted,
                input status, output ready);
endinterface

// ===== design/rv32i_instruction_step.sv =====
// RV32I step block: takes one instruction word per item and returns its effects.
// One item is accepted every clock while the output is not stalled: the instruction
// and its register operands are captured on accept, the execute stage updates the
// PC, halt flag and data memory, and the next stage finishes loads from the banked
// data memory and writes the register file before the output register. The result
// of that write stage is forwarded to the execute stage and bypassed into the
// register file read, so dependent instructions still go back to back. After reset
// the data memory is zeroed one four-byte row per cycle, during which no item is
// accepted.
module rv32i_instruction_step #(
  parameter int MEM_BYTES = rvs_pkg::MEM_BYTES_DEF
) (
  input logic clk,
  input logic rst,
  rvs_in_if.sink    req,
  rvs_out_if.source rsp
);
  import rvs_pkg::*;

  logic        adv, acc, clearing;
  logic        s1_valid;
  logic [31:0] s1_ins;
  logic [31:0] pc;
  logic        halt_flag;
  logic [31:0] qa, qb, op_a, op_b;
  res_t        ex_res;
  mem_req_t    mreq;

  logic        s2_valid;
  res_t        s2_res;
  logic        s2_ld;
  logic [2:0]  s2_f3;
  logic [1:0]  s2_lo;
  logic [3:0][7:0] mq;
  logic [31:0] wv2;
  logic        s2_we;
  res_t        s2_out;
  res_t        o_res;

  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv && !clearing;
  assign acc       = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      rsp.valid <= 1'b0;
      pc        <= '0;
      halt_flag <= 1'b0;
    end else if (adv) begin
      s1_valid  <= acc;
      s2_valid  <= s1_valid;
      rsp.valid <= s2_valid;
      if (s1_valid) begin
        pc        <= ex_res.next_address;
        halt_flag <= ex_res.halted;
      end
    end
  end

  always_comb begin
    s2_out             = s2_res;
    s2_out.write_value = wv2;
  end

  always_ff @(posedge clk) begin
    if (acc) s1_ins <= req.instruction;
    if (adv) begin
      s2_res <= ex_res;
      s2_ld  <= mreq.ld;
      s2_f3  <= mreq.f3;
      s2_lo  <= mreq.addr[1:0];
      o_res  <= s2_out;
    end
  end

  assign s2_we = s2_valid && s2_res.reg_write;
  assign wv2   = (s2_ld && s2_res.reg_write) ? load_value(mq, s2_lo, s2_f3)
                                            : s2_res.write_value;

  // forward from the instruction one stage ahead
  assign op_a = (s2_we && s2_res.dest_reg == s1_ins[19:15]) ? wv2 : qa;
  assign op_b = (s2_we && s2_res.dest_reg == s1_ins[24:20]) ? wv2 : qb;

  rvs_regfile #(.MEM_BYTES(MEM_BYTES)) u_rf (
    .clk   (clk),
    .rst   (rst),
    .we    (adv && s2_we),
    .waddr (s2_res.dest_reg),
    .wdata (wv2),
    .en    (adv),
    .ra    (req.instruction[19:15]),
    .rb    (req.instruction[24:20]),
    .qa    (qa),
    .qb    (qb)
  );

  rvs_exec #(.MEM_BYTES(MEM_BYTES)) u_exec (
    .instruction (s1_ins),
    .pc          (pc),
    .halt_flag   (halt_flag),
    .op_a        (op_a),
    .op_b        (op_b),
    .res         (ex_res),
    .mreq        (mreq)
  );

  rvs_dmem #(.MEM_BYTES(MEM_BYTES)) u_dmem (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .we       (adv && s1_valid && mreq.st),
    .addr     (mreq.addr),
    .size     (mreq.size),
    .wdata    (mreq.sdata),
    .q        (mq),
    .clearing (clearing)
  );

  assign rsp.instr_address = o_res.instr_address;
  assign rsp.next_address  = o_res.next_address;
  assign rsp.reg_write     = o_res.reg_write;
  assign rsp.dest_reg      = o_res.dest_reg;
  assign rsp.write_value   = o_res.write_value;
  assign rsp.branch_taken  = o_res.branch_taken;
  assign rsp.mem_write     = o_res.mem_write;
  assign rsp.halted        = o_res.halted;
  assign rsp.status        = o_res.status;

  a_no_item_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_valid && !s2_valid)
    else $error("item in flight during memory clearing");

  a_fault_keeps_pc: assert property (@(posedge clk) disable iff (rst)
    adv && s1_valid && ex_res.status != ST_OK |=> $stable(pc))
    else $error("faulting instruction moved the PC");

  a_halt_no_effects: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_res.halted |-> !s2_res.reg_write && !s2_res.mem_write &&
                                  !s2_res.branch_taken)
    else $error("halted item has side effects");

  a_x0_never_written: assert property (@(posedge clk) disable iff (rst)
    s2_we |-> s2_res.dest_reg != 5'd0)
    else $error("write to x0");

endmodule

// ===== design/rvs_exec.sv =====
// Decode and execute of one instruction: ALU, branch, jump and address logic.
module rvs_exec #(
  parameter int MEM_BYTES = rvs_pkg::MEM_BYTES_DEF
) (
  input  logic [31:0]      instruction,
  input  logic [31:0]      pc,
  input  logic             halt_flag,
  input  logic [31:0]      op_a,
  input  logic [31:0]      op_b,
  output rvs_pkg::res_t    res,
  output rvs_pkg::mem_req_t mreq
);
  import rvs_pkg::*;

  localparam logic [31:0] MEM_TOP = 32'(MEM_BYTES);

  always_comb begin
    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
    logic [31:0] val, npc, addr;
    logic [2:0]  size;
    logic        wr, taken, ok, ld, st, range_err;

    opc = instruction[6:0];
    rd  = instruction[11:7];
    f3  = instruction[14:12];
    f7  = instruction[31:25];
    imm_i = {{20{instruction[31]}}, instruction[31:20]};
    imm_s = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
    imm_b = {{19{instruction[31]}}, instruction[31], instruction[7], instruction[30:25],
             instruction[11:8], 1'b0};
    imm_j = {{11{instruction[31]}}, instruction[31], instruction[19:12], instruction[20],
             instruction[30:21], 1'b0};
    imm_u = {instruction[31:12], 12'd0};

    val = '0; npc = pc + 32'd4; addr = '0; size = 3'd1;
    wr = 1'b0; taken = 1'b0; ok = 1'b1; ld = 1'b0; st = 1'b0; range_err = 1'b0;

    unique case (opc)
      OP_R: begin
        if (f7 == F7_BASE) ok = (f3 != F3_SLTU);
        else ok = (f7 == F7_ALT) && (f3 == F3_ADD || f3 == F3_SR);
        val = alu_op(f3, f7 == F7_ALT, op_a, op_b);
        wr  = ok;
      end
      OP_I: begin
        if (f3 == F3_SLTU) ok = 1'b0;
        else if (f3 == F3_SLL) ok = (f7 == F7_BASE);
        else if (f3 == F3_SR) ok = (f7 == F7_BASE || f7 == F7_ALT);
        val = alu_op(f3, (f3 == F3_SR) && (f7 == F7_ALT), op_a, imm_i);
        wr  = ok;
      end
      OP_LOAD: begin
        ok   = (f3 == F3_LB || f3 == F3_LH || f3 == F3_LW || f3 == F3_LBU || f3 == F3_LHU);
        size = 3'd1 << f3[1:0];
        addr = op_a + imm_i;
        if (ok && addr > MEM_TOP - 32'(size)) begin
          ok = 1'b0;
          range_err = 1'b1;
        end
        ld = ok;
        wr = ok;
      end
      OP_STORE: begin
        ok   = (f3 <= 3'd2);
        size = 3'd1 << f3[1:0];
        addr = op_a + imm_s;
        if (ok && addr > MEM_TOP - 32'(size)) begin
          ok = 1'b0;
          range_err = 1'b1;
        end
        st = ok;
      end
      OP_BRANCH: begin
        unique case (f3)
          F3_BEQ:  taken = (op_a == op_b);
          F3_BNE:  taken = (op_a != op_b);
          F3_BLT:  taken = $signed(op_a) < $signed(op_b);
          F3_BGE:  taken = !($signed(op_a) < $signed(op_b));
          default: ok = 1'b0;
        endcase
        if (ok && taken) npc = pc + imm_b;
      end
      OP_JAL: begin
        val = pc + 32'd4; wr = 1'b1; taken = 1'b1;
        npc = pc + imm_j;
      end
      OP_JALR: begin
        ok  = (f3 == 3'd0);
        val = pc + 32'd4; wr = ok; taken = ok;
        npc = (op_a + imm_i) & ~32'd1;
      end
      OP_LUI: begin
        val = imm_u; wr = 1'b1;
      end
      OP_AUIPC: begin
        val = pc + imm_u; wr = 1'b1;
      end
      default: ok = 1'b0;
    endcase

    res = '0;
    res.instr_address = pc;
    res.next_address  = pc;
    res.status        = ST_OK;
    mreq = '0;
    mreq.addr  = addr;
    mreq.f3    = f3;
    mreq.size  = size;
    mreq.sdata = op_b;

    if (halt_flag || instruction == HALT_WORD) begin
      res.halted = 1'b1;
    end else if (!ok) begin
      res.status = range_err ? ST_RANGE : ST_ILLEGAL;
    end else begin
      res.next_address = npc;
      res.branch_taken = taken;
      res.mem_write    = st;
      if (wr && rd != 5'd0) begin
        res.reg_write   = 1'b1;
        res.dest_reg    = rd;
        res.write_value = ld ? 32'd0 : val;
      end
      mreq.ld = ld;
      mreq.st = st;
    end
  end

endmodule

// ===== design/rvs_regfile.sv =====
// 32 x 32 register file: one write port, two registered read ports with write bypass.
module rvs_regfile #(
  parameter int MEM_BYTES = rvs_pkg::MEM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        we,
  input  logic [4:0]  waddr,
  input  logic [31:0] wdata,
  input  logic        en,
  input  logic [4:0]  ra,
  input  logic [4:0]  rb,
  output logic [31:0] qa,
  output logic [31:0] qb
);
  import rvs_pkg::*;

  localparam logic [31:0] SP_INIT = 32'(MEM_BYTES - STACK_GAP);

  logic [31:0] mem [32];
  logic [31:0] valid;

  // entries never written read as their reset value
  function automatic logic [31:0] init_val(input logic [4:0] idx);
    return (idx == 5'd2) ? SP_INIT : 32'd0;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (en) begin
      qa <= (we && waddr == ra) ? wdata : (valid[ra] ? mem[ra] : init_val(ra));
      qb <= (we && waddr == rb) ? wdata : (valid[rb] ? mem[rb] : init_val(rb));
    end
  end

endmodule

// ===== design/rvs_dmem.sv =====
// Byte data memory as four byte banks; unaligned access, clearing pass after reset.
module rvs_dmem #(
  parameter int MEM_BYTES = rvs_pkg::MEM_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              we,
  input  logic [31:0]       addr,
  input  logic [2:0]        size,
  input  logic [31:0]       wdata,
  output logic [3:0][7:0]   q,
  output logic              clearing
);
  localparam int ROWS  = (MEM_BYTES + 3) / 4;
  localparam int ROW_W = $clog2(ROWS);

  logic [ROW_W-1:0] clr_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == ROW_W'(ROWS - 1)) clearing <= 1'b0;
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0]       mem [ROWS];
    logic [1:0]       off;
    logic [31:0]      baddr;
    logic [ROW_W-1:0] row;
    logic             active;
    logic [7:0]       rd_q;

    // byte number off of the access falls in this bank
    assign off    = 2'(b) - addr[1:0];
    assign baddr  = addr + 32'(off);
    assign row    = baddr[ROW_W+1:2];
    assign active = {1'b0, off} < size;
    assign q[b]   = rd_q;

    always_ff @(posedge clk) begin
      if (clearing) mem[clr_row] <= '0;
      else if (we && active) mem[row] <= wdata[{off, 3'b000} +: 8];
      if (en) rd_q <= mem[row];
    end
  end

endmodule
